// ===== sv/mfp_pkg.sv =====
// Shared types and constants for the meter frame parser.
package mfp_pkg;

    localparam int ADDR_BYTES     = 7;
    localparam int MIN_TAIL       = 2 + 1;
    localparam int CHK_STOP_BYTES = 2;

    localparam int POS_W          = 9;
    localparam int ADDR_W         = 56;
    localparam int CFG_IDX_W      = 8;

    // Frame offsets
    localparam int POS_TYPE       = 1;
    localparam int POS_ADDR       = 2;
    localparam int POS_CTRL       = 2 + ADDR_BYTES;
    localparam int POS_LEN        = 3 + ADDR_BYTES;
    localparam int DATA_POS       = ADDR_BYTES + 4;
    localparam int MIN_FRAME      = ADDR_BYTES + 4 + MIN_TAIL;
    localparam int LEN_OVERHEAD   = DATA_POS + CHK_STOP_BYTES;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE  = CFG_IDX_W'(1);

    localparam logic [7:0] START_BYTE_RST = 8'h68;
    localparam logic [7:0] STOP_BYTE_RST  = 8'h16;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Report status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [7:0]        payload_byte;
        logic [1:0]        status;
        logic [7:0]        dev_type;
        logic [ADDR_W-1:0] address;
        logic [7:0]        control_code;
        logic [7:0]        payload_length;
    } t_out;

endpackage

// ===== sv/mfp_core.sv =====
// Frame state, configuration registers and per-byte result logic.
module mfp_core import mfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_in                  i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_res_valid,
    output t_out                 o_res
);

    logic [7:0]        r_start_byte;
    logic [7:0]        r_stop_byte;
    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_sum;
    logic [7:0]        r_prev;
    logic              r_start_ok;
    logic [7:0]        r_type;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_ctrl;
    logic [7:0]        r_len;

    logic [POS_W:0]    pos_ext;
    logic [POS_W:0]    size;
    logic              payload_hit;
    logic              fmt_bad;
    logic [1:0]        status;

    assign pos_ext = {1'b0, r_pos};
    assign size    = pos_ext + (POS_W+1)'(1);

    assign payload_hit = !i_in.frame_end
                      && (pos_ext >= (POS_W+1)'(DATA_POS))
                      && (pos_ext < ((POS_W+1)'(DATA_POS) + (POS_W+1)'(r_len)));

    assign fmt_bad = !r_start_ok
                  || (i_in.rx_byte != r_stop_byte)
                  || (((POS_W+1)'(r_len) + (POS_W+1)'(LEN_OVERHEAD)) != size)
                  || (r_prev != r_sum);

    always_comb begin
        priority if (size < (POS_W+1)'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (fmt_bad) begin
            status = ST_FORMAT;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = i_in.frame_end || payload_hit;
        if (i_in.frame_end) begin
            o_res.kind           = KIND_REPORT;
            o_res.status         = status;
            o_res.dev_type       = r_type;
            o_res.address        = r_addr;
            o_res.control_code   = r_ctrl;
            o_res.payload_length = r_len;
        end else begin
            o_res.kind         = KIND_PAYLOAD;
            o_res.payload_byte = i_in.rx_byte;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_stop_byte  <= STOP_BYTE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_START_BYTE) begin
                r_start_byte <= i_cfg_data;
            end
            if (i_cfg_index == REG_STOP_BYTE) begin
                r_stop_byte <= i_cfg_data;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_in.frame_end)) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_prev     <= '0;
            r_start_ok <= 1'b0;
            r_type     <= '0;
            r_addr     <= '0;
            r_ctrl     <= '0;
            r_len      <= '0;
        end else if (i_accept) begin
            r_prev <= i_in.rx_byte;
            if (r_pos == '0) begin
                r_sum      <= '0;
                r_start_ok <= (i_in.rx_byte == r_start_byte);
                r_type     <= '0;
                r_addr     <= '0;
                r_ctrl     <= '0;
                r_len      <= '0;
            end else begin
                r_sum <= r_sum + r_prev;
            end
            if (r_pos == POS_W'(POS_TYPE)) begin
                r_type <= i_in.rx_byte;
            end
            for (int k = 0; k < ADDR_BYTES; k++) begin
                if (r_pos == POS_W'(POS_ADDR + k)) begin
                    r_addr[8*k +: 8] <= i_in.rx_byte;
                end
            end
            if (r_pos == POS_W'(POS_CTRL)) begin
                r_ctrl <= i_in.rx_byte;
            end
            if (r_pos == POS_W'(POS_LEN)) begin
                r_len <= i_in.rx_byte;
            end
            // saturating position
            if (r_pos != '1) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

endmodule

// ===== sv/mfp_skid.sv =====
// Output register with a skid stage.
module mfp_skid import mfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_full,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic r_main_valid;
    t_out r_main;
    logic r_skid_valid;
    t_out r_skid;
    logic pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== sv/meter_frame_parser.sv =====
// Byte-serial meter frame parser: top level.
// Takes one frame byte per transaction (frame_end on the last byte) and
// sustains one byte per clock while o_in_stall is low. A frame is start,
// meter type, ADDR_BYTES address bytes, control, length, payload,
// checksum, stop. Payload bytes are forwarded as kind 0 results through
// the registered output stage, before any check; the final byte yields a
// kind 1 report with the header fields and a status (ok, too short, format
// error). Other bytes give no result. The output side is a register plus
// a one-entry skid stage, so o_in_stall only rises once two results are
// held while i_out_stall stays high. Frame state is a running position
// counter (saturating at 511), a lagging 8-bit sum and held header bytes,
// updated once for each byte taken. Configuration (start and stop byte)
// is written through the cfg channel, always ready; unknown indexes are
// ignored.
module meter_frame_parser import mfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic accept;
    logic res_valid;
    t_out res;
    logic skid_full;

    // a byte is taken whenever the skid stage has room
    assign o_in_stall  = skid_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    mfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mfp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

// ===== sv/mfp_checker.sv =====
// Port-level assertions for the meter frame parser, bound to the top level.
module mfp_checker import mfp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // held result stays offered while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input back-pressure only follows a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // reports carry a defined status and no payload byte
    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_REPORT) |->
            (o_out_data.status != 2'd3) && (o_out_data.payload_byte == 8'd0))
        else $error("malformed report");

endmodule

bind meter_frame_parser mfp_checker u_mfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/mfp_frame_check.sv =====
`timescale 1ns / 1ps
// Result checker for the meter frame parser: follows every byte taken and compares each result.
module mfp_frame_check import mfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [7:0]        start_cfg;
    logic [7:0]        stop_cfg;

    // frame state as the parser should hold it
    logic [POS_W-1:0]  pos;
    logic [7:0]        sum_lag;
    logic [7:0]        prev_byte;
    logic              start_ok;
    logic [7:0]        hdr_type;
    logic [ADDR_W-1:0] hdr_addr;
    logic [7:0]        hdr_ctrl;
    logic [7:0]        hdr_len;

    t_out              results_due[$];
    int                fails;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic clear_frame;
        pos       = '0;
        sum_lag   = '0;
        prev_byte = '0;
        start_ok  = 1'b0;
        hdr_type  = '0;
        hdr_addr  = '0;
        hdr_ctrl  = '0;
        hdr_len   = '0;
    endtask

    // Work out what one accepted byte should produce.
    task automatic parse_byte(input t_in item);
        int   p;
        int   size;
        t_out res;
        p   = pos;
        res = '0;
        if (item.frame_end) begin
            size     = p + 1;
            res.kind = KIND_REPORT;
            if (size < MIN_FRAME)
                res.status = ST_SHORT;
            else if (!start_ok || item.rx_byte != stop_cfg ||
                     int'(hdr_len) + LEN_OVERHEAD != size || prev_byte != sum_lag)
                res.status = ST_FORMAT;
            else
                res.status = ST_OK;
            res.dev_type       = hdr_type;
            res.address        = hdr_addr;
            res.control_code   = hdr_ctrl;
            res.payload_length = hdr_len;
            results_due.push_back(res);
            clear_frame();
        end else begin
            if (p == 0) begin
                clear_frame();
                start_ok = (item.rx_byte == start_cfg);
            end else begin
                sum_lag = sum_lag + prev_byte;
            end
            prev_byte = item.rx_byte;
            if (p == POS_TYPE)
                hdr_type = item.rx_byte;
            else if (p >= POS_ADDR && p < POS_ADDR + ADDR_BYTES)
                hdr_addr[8*(p-POS_ADDR) +: 8] = item.rx_byte;
            else if (p == POS_CTRL)
                hdr_ctrl = item.rx_byte;
            else if (p == POS_LEN)
                hdr_len = item.rx_byte;
            if (pos != '1)
                pos = pos + 1'b1;
            if (p >= DATA_POS && p < DATA_POS + int'(hdr_len)) begin
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = item.rx_byte;
                results_due.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("result %h with none outstanding", got));
            return;
        end
        want = results_due.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("payload_byte", got.payload_byte, want.payload_byte);
        check_field("status", got.status, want.status);
        check_field("dev_type", got.dev_type, want.dev_type);
        check_field("address", got.address, want.address);
        check_field("control_code", got.control_code, want.control_code);
        check_field("payload_length", got.payload_length, want.payload_length);
    endtask

    // Results are taken before bytes, so a result can never match a byte
    // accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_cfg = START_BYTE_RST;
            stop_cfg  = STOP_BYTE_RST;
            clear_frame();
            results_due.delete();
        end else begin
            if ($isunknown(i_out_valid))
                report_mismatch("output valid unknown");
            if (i_out_valid && !i_out_stall)
                check_result(i_out_data);
            if (i_in_valid && !i_in_stall)
                parse_byte(i_in_data);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_START_BYTE)
                    start_cfg = i_cfg_data;
                else if (i_cfg_index == REG_STOP_BYTE)
                    stop_cfg = i_cfg_data;
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/meter_frame_parser_test.sv =====
`timescale 1ns / 1ps
// Test top for the meter frame parser: clock, reset, frame stimulus and verdict.
module meter_frame_parser_test;
    import mfp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    // ~700 bytes with random idles and stalls; the limit is many times what they need
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 500;
    localparam int PHASE_BYTES   = 100;
    localparam int SETTLE_CYCLES = 4;

    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_STOP_BYTE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    // how a frame is built (or broken)
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_START,
        SHAPE_BAD_STOP,
        SHAPE_BAD_SUM,
        SHAPE_BAD_LEN,
        SHAPE_CUT,
        SHAPE_NOISE
    } t_frame_shape;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles    = 0;
    int bytes_sent = 0;
    int idle_pct  = 36;
    int stall_pct = 36;

    // delimiters as currently programmed, used to build well-formed frames
    logic [7:0] start_val = START_BYTE_RST;
    logic [7:0] stop_val  = STOP_BYTE_RST;
    logic [7:0] frame_q[$];

    meter_frame_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mfp_frame_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF clk = ~clk;

    // Receiver back-pressure: a fresh coin toss every cycle, so stalls land
    // on payload transactions and reports alike.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] pick(input int fill);
        return (fill < 0) ? 8'($urandom) : 8'(fill);
    endfunction

    // non-zero mask, so a corrupted byte always differs
    function automatic logic [7:0] flip();
        return 8'($urandom_range(255, 1));
    endfunction

    // One byte transaction. Valid may drop first, as long as random idling lasts;
    // once raised it holds with the same payload until the parser takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame;
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Lay out start, type, address, control, length, payload, checksum and
    // stop, then damage it as the shape says. The length byte is always
    // len; only a bad-length frame carries len+extra payload bytes. The
    // checksum is taken over whatever went in, so each fault stays alone.
    // fill < 0 gives random content, otherwise every content byte is fill.
    task automatic build_frame(input t_frame_shape shape, input int len, input int extra,
                               input int fill);
        logic [7:0] sum;
        int         count;
        int         keep;
        frame_q.delete();
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(30, 1))
                frame_q.push_back(8'($urandom));
            return;
        end
        count = (shape == SHAPE_BAD_LEN) ? len + extra : len;
        if (count < 0)
            count = 0;
        frame_q.push_back(shape == SHAPE_BAD_START ? start_val ^ flip() : start_val);
        // meter type, address bytes and control
        repeat (ADDR_BYTES + 2)
            frame_q.push_back(pick(fill));
        frame_q.push_back(8'(len));
        repeat (count)
            frame_q.push_back(pick(fill));
        sum = '0;
        foreach (frame_q[i])
            sum += frame_q[i];
        frame_q.push_back(shape == SHAPE_BAD_SUM ? sum ^ flip() : sum);
        frame_q.push_back(shape == SHAPE_BAD_STOP ? stop_val ^ flip() : stop_val);
        // early end: the final byte may land in the header, the payload or the checksum
        if (shape == SHAPE_CUT) begin
            keep = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
    endtask

    // Register write transaction. With more set, valid stays high for the
    // write that follows.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value,
                             input logic more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_START_BYTE)
            start_val = value;
        else if (idx == REG_STOP_BYTE)
            stop_val = value;
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every outstanding result; a byte that makes
    // no result may still be in flight, hence the extra cycles.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial begin
        int           phase;
        int           phase_end;
        int           random_target;
        int           roll;
        int           len;
        int           extra;
        t_frame_shape shape;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part, reset delimiters ---
        // a frame that is nothing but its final byte
        send_byte(8'h00, 1'b1);
        // smallest good frame, every content byte all ones
        build_frame(SHAPE_GOOD, 1, 0, 8'hFF);
        send_frame();
        // zero length can never reach the minimum size
        build_frame(SHAPE_GOOD, 0, 0, 8'h00);
        send_frame();
        drain();

        // out-of-range indexes must leave both delimiters alone
        cfg_write(REG_UNUSED_LO, 8'h00, 1'b1);
        cfg_write(REG_UNUSED_HI, 8'hFF, 1'b0);
        build_frame(SHAPE_GOOD, 2, 0, -1);
        send_frame();

        // --- random part, one delimiter setting per phase ---
        random_target = bytes_sent + RANDOM_BYTES;
        for (phase = 0; bytes_sent < random_target; phase++) begin
            // sender pauses until every expected result is back
            drain();
            unique case (phase)
                0: begin
                    // extremes, and a stretch with no idling on either side
                    cfg_write(REG_START_BYTE, 8'h00, 1'b1);
                    cfg_write(REG_STOP_BYTE, 8'hFF, 1'b0);
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    cfg_write(REG_START_BYTE, 8'hFF, 1'b1);
                    cfg_write(REG_STOP_BYTE, 8'h00, 1'b0);
                    idle_pct = 36;
                    stall_pct <= 36;
                    // runs past the position limit
                    build_frame(SHAPE_BAD_LEN, 255, 250, -1);
                    send_frame();
                end
                default: begin
                    cfg_write(REG_START_BYTE, 8'($urandom), 1'b1);
                    cfg_write(REG_STOP_BYTE, 8'($urandom), 1'b0);
                end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end && bytes_sent < random_target) begin
                roll = $urandom_range(99);
                if (roll < 60)
                    shape = SHAPE_GOOD;
                else if (roll < 66)
                    shape = SHAPE_BAD_START;
                else if (roll < 72)
                    shape = SHAPE_BAD_STOP;
                else if (roll < 78)
                    shape = SHAPE_BAD_SUM;
                else if (roll < 85)
                    shape = SHAPE_BAD_LEN;
                else if (roll < 93)
                    shape = SHAPE_CUT;
                else
                    shape = SHAPE_NOISE;
                // mostly short payloads, now and then a long one
                roll = $urandom_range(99);
                if (roll < 90)
                    len = $urandom_range(8);
                else if (roll < 97)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(255, 41);
                extra = $urandom_range(3, 1);
                if ($urandom_range(1))
                    extra = -extra;
                build_frame(shape, len, extra, -1);
                send_frame();
            end
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== meter_frame_parser.f =====
sv/mfp_pkg.sv
sv/mfp_core.sv
sv/mfp_skid.sv
sv/meter_frame_parser.sv
sv/mfp_checker.sv
tb/mfp_frame_check.sv
tb/meter_frame_parser_test.sv
